// File: sv/hmr_pkg.sv
// Shared types, sizes and codes of the HID message reassembler.
package hmr_pkg;

    // Report buffer sizing.
    localparam int PACKET_BYTES = 64;
    localparam int ADDR_W       = $clog2(PACKET_BYTES);
    localparam int LEN_W        = $clog2(PACKET_BYTES + 1);

    // Report layout.
    localparam int INIT_HDR     = 7;
    localparam int INIT_MIN_LEN = 8;
    localparam int CONT_HDR     = 5;
    localparam int TYPE_BIT     = 7;
    localparam int HDR_IDX_W    = 3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'b1;

    localparam logic [15:0] MAX_BYTES_RESET = 16'd7609;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;

    // Input item kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_SEQ = 2'd1;
    localparam logic [1:0] ST_BAD_PKT = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       packet_end;
    } t_in_item;

    typedef struct packed {
        logic        has_byte;
        logic [7:0]  payload_byte;
        logic [31:0] channel_id;
        logic [7:0]  command;
        logic        last;
        logic [1:0]  status;
    } t_out_item;

    // Read request from the sequencer to the report buffer.
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_buf_rd;

endpackage

// File: sv/hmr_pkt_buf.sv
// Report buffer: byte memory with fill counter and latched report length.
module hmr_pkt_buf (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [7:0]                i_wr_data,
    input  logic                      i_wr_end,
    input  hmr_pkg::t_buf_rd          i_rd,
    output logic [7:0]                o_rd_data,
    output logic [hmr_pkg::LEN_W-1:0] o_pkt_len
);

    logic [7:0]                mem [hmr_pkg::PACKET_BYTES];
    logic [7:0]                r_rd_data;
    logic [hmr_pkg::LEN_W-1:0] r_fill;
    logic [hmr_pkg::LEN_W-1:0] r_len;
    logic                      has_room;
    logic [hmr_pkg::LEN_W-1:0] fill_inc;

    // Bytes beyond the buffer size are dropped.
    assign has_room = r_fill < hmr_pkg::LEN_W'(hmr_pkg::PACKET_BYTES);
    assign fill_inc = has_room ? hmr_pkg::LEN_W'(r_fill + 1'b1) : r_fill;

    // Memory with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en && has_room) begin
            mem[r_fill[hmr_pkg::ADDR_W-1:0]] <= i_wr_data;
        end
        if (i_rd.rd_en) begin
            r_rd_data <= mem[i_rd.rd_addr];
        end
    end

    // Fill counter restarts at each report end, when the length is latched.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_len  <= '0;
        end else if (i_wr_en) begin
            if (i_wr_end) begin
                r_fill <= '0;
                r_len  <= fill_inc;
            end else begin
                r_fill <= fill_inc;
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_pkt_len = r_len;

endmodule

// File: sv/hmr_ctrl.sv
// Sequencer: header readout, message decisions, payload readout and result register.
module hmr_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  hmr_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output hmr_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hmr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_wdata,
    output hmr_pkg::t_buf_rd              o_rd,
    input  logic [7:0]                    i_rd_data,
    input  logic [hmr_pkg::LEN_W-1:0]     i_pkt_len
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_HDR      = 3'd1;
    localparam logic [2:0] S_DECIDE   = 3'd2;
    localparam logic [2:0] S_PAY_RD   = 3'd3;
    localparam logic [2:0] S_PAY_OUT  = 3'd4;
    localparam logic [2:0] S_EMIT     = 3'd5;

    localparam int LW = hmr_pkg::LEN_W;

    logic [2:0]    r_state, n_state;
    logic [LW-1:0] r_ptr, n_ptr;
    logic          r_in_msg, n_in_msg;
    logic [15:0]   r_rem, n_rem;
    logic [7:0]    r_seq, n_seq;
    logic [31:0]   r_chan, n_chan;
    logic [7:0]    r_cmd, n_cmd;
    logic [15:0]   r_wait, n_wait;
    logic [1:0]    r_status, n_status;
    logic [15:0]   r_max_bytes;
    logic [15:0]   r_timeout;
    logic [7:0]    r_hdr [hmr_pkg::INIT_HDR];

    logic                 r_out_valid;
    hmr_pkg::t_out_item   r_out_data, n_out_data;
    logic                 load_out;

    logic          in_acc;
    logic          out_free;
    logic          tick;
    logic          pkt_done;
    logic [15:0]   wait_inc;
    logic [15:0]   count;
    logic [LW-1:0] ptr_m1;

    assign o_in_stall  = r_state != S_IDLE;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign tick        = in_acc && (i_in_data.kind == hmr_pkg::KIND_TICK);
    assign pkt_done    = in_acc && (i_in_data.kind == hmr_pkg::KIND_BYTE)
                         && i_in_data.packet_end;
    assign wait_inc    = (r_wait == 16'hFFFF) ? r_wait : 16'(r_wait + 16'd1);
    assign count       = {r_hdr[5], r_hdr[6]};
    assign ptr_m1      = LW'(r_ptr - 1'b1);
    assign o_cfg_ready = 1'b1;

    // Next-state and result logic.
    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_in_msg   = r_in_msg;
        n_rem      = r_rem;
        n_seq      = r_seq;
        n_chan     = r_chan;
        n_cmd      = r_cmd;
        n_wait     = r_wait;
        n_status   = r_status;
        load_out   = 1'b0;
        n_out_data = r_out_data;
        o_rd.rd_en   = 1'b0;
        o_rd.rd_addr = r_ptr[hmr_pkg::ADDR_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (tick && r_in_msg) begin
                    if (wait_inc >= r_timeout) begin
                        n_in_msg = 1'b0;
                        n_rem    = '0;
                        n_wait   = '0;
                        n_status = hmr_pkg::ST_TIMEOUT;
                        n_state  = S_EMIT;
                    end else begin
                        n_wait = wait_inc;
                    end
                end else if (pkt_done) begin
                    n_ptr   = '0;
                    n_state = S_HDR;
                end
            end
            S_HDR: begin
                // Read header bytes 0 to 6, one a cycle.
                if (r_ptr == LW'(hmr_pkg::INIT_HDR)) begin
                    n_state = S_DECIDE;
                end else begin
                    o_rd.rd_en = 1'b1;
                    n_ptr      = LW'(r_ptr + 1'b1);
                end
            end
            S_DECIDE: begin
                if (!r_in_msg) begin
                    // Idle: only a valid init report within the size limit starts a message.
                    if (i_pkt_len < LW'(hmr_pkg::INIT_MIN_LEN) ||
                        !r_hdr[4][hmr_pkg::TYPE_BIT] || count > r_max_bytes) begin
                        n_state = S_IDLE;
                    end else begin
                        n_chan = {r_hdr[3], r_hdr[2], r_hdr[1], r_hdr[0]};
                        n_cmd  = r_hdr[4];
                        if (count == 16'd0) begin
                            n_status = hmr_pkg::ST_OK;
                            n_state  = S_EMIT;
                        end else begin
                            n_rem    = count;
                            n_ptr    = LW'(hmr_pkg::INIT_HDR);
                            n_in_msg = 1'b1;
                            n_seq    = '0;
                            n_wait   = '0;
                            n_state  = S_PAY_RD;
                        end
                    end
                end else if (i_pkt_len < LW'(hmr_pkg::CONT_HDR) ||
                             r_hdr[4][hmr_pkg::TYPE_BIT]) begin
                    n_in_msg = 1'b0;
                    n_rem    = '0;
                    n_wait   = '0;
                    n_status = hmr_pkg::ST_BAD_PKT;
                    n_state  = S_EMIT;
                end else if (r_hdr[4] != r_seq) begin
                    n_in_msg = 1'b0;
                    n_rem    = '0;
                    n_wait   = '0;
                    n_status = hmr_pkg::ST_BAD_SEQ;
                    n_state  = S_EMIT;
                end else begin
                    n_seq   = 8'(r_seq + 8'd1);
                    n_wait  = '0;
                    n_ptr   = LW'(hmr_pkg::CONT_HDR);
                    n_state = S_PAY_RD;
                end
            end
            S_PAY_RD: begin
                // Fetch the next payload byte while the report and the count last.
                if (r_ptr < i_pkt_len && r_rem != 16'd0) begin
                    o_rd.rd_en = 1'b1;
                    n_state    = S_PAY_OUT;
                end else begin
                    if (r_rem == 16'd0) begin
                        n_in_msg = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            S_PAY_OUT: begin
                if (out_free) begin
                    load_out                = 1'b1;
                    n_out_data.has_byte     = 1'b1;
                    n_out_data.payload_byte = i_rd_data;
                    n_out_data.channel_id   = r_chan;
                    n_out_data.command      = r_cmd;
                    n_out_data.last         = r_rem == 16'd1;
                    n_out_data.status       = hmr_pkg::ST_OK;
                    n_ptr                   = LW'(r_ptr + 1'b1);
                    n_rem                   = 16'(r_rem - 16'd1);
                    n_state                 = S_PAY_RD;
                end
            end
            S_EMIT: begin
                // Single result for an empty message or an abort.
                if (out_free) begin
                    load_out                = 1'b1;
                    n_out_data.has_byte     = 1'b0;
                    n_out_data.payload_byte = 8'd0;
                    n_out_data.channel_id   = r_chan;
                    n_out_data.command      = r_cmd;
                    n_out_data.last         = 1'b1;
                    n_out_data.status       = r_status;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ptr    <= '0;
            r_in_msg <= 1'b0;
            r_rem    <= '0;
            r_seq    <= '0;
            r_chan   <= '0;
            r_cmd    <= '0;
            r_wait   <= '0;
            r_status <= hmr_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_in_msg <= n_in_msg;
            r_rem    <= n_rem;
            r_seq    <= n_seq;
            r_chan   <= n_chan;
            r_cmd    <= n_cmd;
            r_wait   <= n_wait;
            r_status <= n_status;
        end
    end

    // Header bytes come from the registered read port and are stored in the cycle after their read.
    always_ff @(posedge i_clk) begin
        if (r_state == S_HDR && r_ptr != '0) begin
            r_hdr[ptr_m1[hmr_pkg::HDR_IDX_W-1:0]] <= i_rd_data;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= hmr_pkg::MAX_BYTES_RESET;
            r_timeout   <= hmr_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hmr_pkg::CFG_MAX_BYTES: r_max_bytes <= i_cfg_wdata;
                hmr_pkg::CFG_TIMEOUT:   r_timeout   <= i_cfg_wdata;
            endcase
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: sv/hid_message_reassembler.sv
// Top level of the HID message reassembler: report buffer and sequencer.
//
//  Channel   Signals                                   Beat taken when
//  input     i_in_valid, o_in_stall, i_in_data         i_in_valid && !o_in_stall
//  result    o_out_valid, i_out_stall, o_out_data      o_out_valid && !i_out_stall
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index,    i_cfg_valid && o_cfg_ready
//            i_cfg_wdata
//
// A tick or a report byte that does not end a report is taken without a stall; a tick that times
// the message out then stalls the input while its result is loaded.
// A report end stalls the input through header readout and decision, then through payload
// readout, one fetch and one output per byte, or through a single result, unless it is dropped.
// Results wait in an output register; a stalled result holds the sequencer and so the input.
// Reset is synchronous and active low; the buffer contents are not cleared.
module hid_message_reassembler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  hmr_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output hmr_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hmr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_wdata
);

    hmr_pkg::t_buf_rd              rd_req;
    logic [7:0]                    rd_data;
    logic [hmr_pkg::LEN_W-1:0]     pkt_len;
    logic                          byte_wr;

    // Report bytes go straight into the buffer when accepted.
    assign byte_wr = i_in_valid && !o_in_stall && (i_in_data.kind == hmr_pkg::KIND_BYTE);

    hmr_pkt_buf u_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (byte_wr),
        .i_wr_data (i_in_data.data_byte),
        .i_wr_end  (i_in_data.packet_end),
        .i_rd      (rd_req),
        .o_rd_data (rd_data),
        .o_pkt_len (pkt_len)
    );

    hmr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rd        (rd_req),
        .i_rd_data   (rd_data),
        .i_pkt_len   (pkt_len)
    );

endmodule

// File: sv/hmr_checker.sv
// Port-level assertions for the HID message reassembler, with their bind.
module hmr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input hmr_pkg::t_in_item             i_in_data,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input hmr_pkg::t_out_item            o_out_data
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // A result without a byte is always the end of a message or an abort.
    a_nobyte_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.has_byte |-> o_out_data.last &&
        o_out_data.payload_byte == 8'd0)
        else $error("byte-less result not final or payload not zero");

    // Payload bytes only come with an ok status.
    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.has_byte |-> o_out_data.status == hmr_pkg::ST_OK)
        else $error("payload byte with error status");

    // A report byte that does not end a report never blocks the next beat.
    a_byte_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.kind == hmr_pkg::KIND_BYTE &&
        !i_in_data.packet_end |=> !o_in_stall)
        else $error("stall after a mid-report byte");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind hid_message_reassembler hmr_checker u_hmr_checker (.*);
